[rtl/fbc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and codes for the frustum box cull block.
// No dependencies; every other file imports this package.
package fbc_pkg;

	// Register file
	localparam int NUM_REGS      = 8;
	localparam int CFG_IDX_W     = 4;
	localparam int REG_W         = 64;
	localparam int REG_PROJ_ROW0 = 0;
	localparam int REG_CAM_ROW0  = 4;

	// Planes and arithmetic widths
	localparam int NUM_PLANES = 6;
	localparam logic [2:0] PLANE_LAST = 3'(NUM_PLANES - 1);
	localparam int VW    = 34;  // one entry of P*C, Q18.16
	localparam int PW    = 35;  // one plane component, Q19.16
	localparam int BW    = 17;  // second multiplier operand
	localparam int PRODW = PW + BW;
	localparam int SUMW  = 56;  // plane distance and radius, Q32.24

	// Result codes
	localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
	localparam logic [1:0] VERDICT_INSIDE  = 2'd1;
	localparam logic [1:0] VERDICT_CROSS   = 2'd2;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;
	typedef logic signed [PW-1:0] plane_comp_t;

	typedef enum logic {
		OP_MAT,
		OP_TEST
	} op_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BUILD,
		S_FLUSH,
		S_TEST,
		S_DONE
	} state_e;

	// One issue into the shared multiply unit
	typedef struct packed {
		logic       valid;
		op_e        op;
		logic [1:0] row;
		logic [1:0] col;
		logic [2:0] plane;
	} issue_t;

	// Outcome of one plane test
	typedef struct packed {
		logic       valid;
		logic [2:0] plane;
		logic       outside;
		logic       cut;
	} eval_t;

	// Identity row after reset: 1.0 on the diagonal
	function automatic logic [REG_W-1:0] cfg_reset_row(input logic [2:0] idx);
		cfg_reset_row = 64'h0000_0000_0000_0100 << {idx[1:0], 4'b0000};
	endfunction

endpackage

[rtl/fbc_cfg.sv]
`timescale 1ns / 1ps
// Configuration register file (projection and camera rows) and plane staleness flag.
// Depends on fbc_pkg.
module fbc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [fbc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [fbc_pkg::REG_W-1:0]      wr_data,
	input  logic                           stale_clear,
	output fbc_pkg::cfg_regs_t             regs,
	output logic                           stale
);
	import fbc_pkg::*;

	cfg_regs_t regs_q;
	logic      stale_q;

	// Take register beats; any listed write marks the planes stale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= cfg_reset_row(3'(i));
			end
			stale_q <= 1'b1;
		end else if (wr_en && (wr_index < CFG_IDX_W'(NUM_REGS))) begin
			regs_q[wr_index[2:0]] <= wr_data;
			stale_q               <= 1'b1;
		end else if (stale_clear) begin
			stale_q <= 1'b0;
		end
	end

	assign regs  = regs_q;
	assign stale = stale_q;

endmodule

[rtl/fbc_datapath.sv]
`timescale 1ns / 1ps
// Shared six-multiplier unit with registered products, plane store and plane test.
// Depends on fbc_pkg; driven by fbc_ctrl.
module fbc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic signed [15:0]  centre_x,
	input  logic signed [15:0]  centre_y,
	input  logic signed [15:0]  centre_z,
	input  logic [14:0]         extent_x,
	input  logic [14:0]         extent_y,
	input  logic [14:0]         extent_z,
	input  fbc_pkg::cfg_regs_t  regs,
	input  fbc_pkg::issue_t     iss,
	output fbc_pkg::eval_t      ev
);
	import fbc_pkg::*;

	logic signed [15:0]   cen_q [3];
	logic [14:0]          ext_q [3];
	plane_comp_t          plane_q [NUM_PLANES][4];
	logic signed [VW-1:0] v3_q [4];

	plane_comp_t          op_a [6];
	logic signed [BW-1:0] op_b [6];

	logic signed [PRODW-1:0] prod_s1 [6];
	plane_comp_t             p3_s1;
	logic                    valid_s1;
	op_e                     op_s1;
	logic [1:0]              row_s1;
	logic [1:0]              col_s1;
	logic [2:0]              plane_s1;

	logic signed [SUMW-1:0] mat_sum;
	logic signed [VW-1:0]   v_new;
	plane_comp_t            pl_sum;
	plane_comp_t            pl_diff;
	logic signed [SUMW-1:0] dist_sum;
	logic signed [SUMW-1:0] rad;
	logic signed [SUMW-1:0] near_side;
	logic signed [SUMW-1:0] far_side;
	logic                   in_front;
	logic                   far_pos;

	// Hold the box for the whole test
	always_ff @(posedge clk) begin
		if (accept) begin
			cen_q[0] <= centre_x;
			cen_q[1] <= centre_y;
			cen_q[2] <= centre_z;
			ext_q[0] <= extent_x;
			ext_q[1] <= extent_y;
			ext_q[2] <= extent_z;
		end
	end

	// Route operands: matrix entries for a rebuild, plane and box for a test
	always_comb begin
		logic signed [15:0] pe;
		logic signed [15:0] ce;
		plane_comp_t        pc;
		pe = '0;
		ce = '0;
		pc = '0;
		for (int k = 0; k < 6; k++) begin
			op_a[k] = '0;
			op_b[k] = '0;
		end
		if (iss.op == OP_MAT) begin
			for (int k = 0; k < 4; k++) begin
				pe      = signed'(regs[{1'b0, iss.row}][16*k +: 16]);
				ce      = signed'(regs[3'(REG_CAM_ROW0 + k)][{iss.col, 4'b0000} +: 16]);
				op_a[k] = PW'(pe);
				op_b[k] = BW'(ce);
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				pc          = plane_q[iss.plane][k];
				op_a[k]     = pc;
				op_b[k]     = BW'(cen_q[k]);
				op_a[k + 3] = pc[PW-1] ? -pc : pc;
				op_b[k + 3] = signed'({2'b00, ext_q[k]});
			end
		end
	end

	// Multiply and register the products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= iss.valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			prod_s1[k] <= op_a[k] * op_b[k];
		end
		p3_s1    <= plane_q[iss.plane][3];
		op_s1    <= iss.op;
		row_s1   <= iss.row;
		col_s1   <= iss.col;
		plane_s1 <= iss.plane;
	end

	// Combine: one matrix entry and its two planes, or one plane distance
	always_comb begin
		mat_sum = SUMW'(prod_s1[0]) + SUMW'(prod_s1[1])
		        + SUMW'(prod_s1[2]) + SUMW'(prod_s1[3]);
		v_new   = mat_sum[VW-1:0];
		pl_sum  = PW'(v3_q[col_s1]) + PW'(v_new);
		pl_diff = PW'(v3_q[col_s1]) - PW'(v_new);

		dist_sum = (SUMW'(p3_s1) <<< 8) + SUMW'(prod_s1[0])
		         + SUMW'(prod_s1[1]) + SUMW'(prod_s1[2]);
		rad  = SUMW'(prod_s1[3]) + SUMW'(prod_s1[4]) + SUMW'(prod_s1[5]);
		near_side = dist_sum - rad;
		far_side  = dist_sum + rad;
		in_front  = !near_side[SUMW-1];
		far_pos   = !far_side[SUMW-1] && (far_side != '0);
	end

	assign ev.valid   = valid_s1 && (op_s1 == OP_TEST);
	assign ev.plane   = plane_s1;
	assign ev.outside = !in_front && !far_pos;
	assign ev.cut     = !in_front && far_pos;

	// Write back row 3 of P*C, or the plane pair built from another row
	always_ff @(posedge clk) begin
		if (valid_s1 && (op_s1 == OP_MAT)) begin
			if (row_s1 == 2'd3) begin
				v3_q[col_s1] <= v_new;
			end else begin
				plane_q[{row_s1, 1'b0}][col_s1] <= (row_s1 == 2'd1) ? pl_diff : pl_sum;
				plane_q[{row_s1, 1'b1}][col_s1] <= (row_s1 == 2'd1) ? pl_sum : pl_diff;
			end
		end
	end

endmodule

[rtl/fbc_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer: plane rebuild, cyclic plane tests with early exit, result hand-off.
// Depends on fbc_pkg; drives fbc_datapath.
module fbc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [2:0]       hint_in,
	input  logic             stale,
	input  logic             out_free,
	input  fbc_pkg::eval_t   ev,
	output logic             in_stall,
	output logic             accept,
	output logic             stale_clear,
	output fbc_pkg::issue_t  iss,
	output logic             load,
	output logic [1:0]       res_verdict,
	output logic [2:0]       res_hint
);
	import fbc_pkg::*;

	state_e     state_q;
	state_e     state_d;
	logic [3:0] cnt_q;
	logic [2:0] icnt_q;
	logic [2:0] ecnt_q;
	logic [2:0] plane_q;
	logic [2:0] start_q;
	logic       cut_q;
	logic [1:0] verdict_q;
	logic [2:0] hint_q;

	logic [2:0] hint_fix;
	logic       ev_test;
	logic       reject;
	logic       last;

	assign hint_fix = (hint_in > PLANE_LAST) ? 3'd0 : hint_in;
	assign ev_test  = (state_q == S_TEST) && ev.valid;
	assign reject   = ev_test && ev.outside;
	assign last     = ev_test && (ecnt_q == PLANE_LAST);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = stale ? S_BUILD : S_TEST;
			S_BUILD: if (cnt_q == 4'hF) state_d = S_FLUSH;
			S_FLUSH: state_d = S_TEST;
			S_TEST:  if (reject || last) state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall    = 1'b1;
		accept      = 1'b0;
		stale_clear = 1'b0;
		load        = 1'b0;
		iss         = '0;
		unique case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				accept      = in_valid;
				stale_clear = in_valid && stale;
			end
			S_BUILD: begin
				iss.valid = 1'b1;
				iss.op    = OP_MAT;
				iss.row   = cnt_q[3:2] - 2'd1;
				iss.col   = cnt_q[1:0];
			end
			S_TEST: begin
				iss.valid = (icnt_q < 3'(NUM_PLANES));
				iss.op    = OP_TEST;
				iss.plane = plane_q;
			end
			S_DONE: begin
				load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Advance counters and collect the verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			icnt_q    <= '0;
			ecnt_q    <= '0;
			plane_q   <= '0;
			start_q   <= '0;
			cut_q     <= 1'b0;
			verdict_q <= VERDICT_INSIDE;
			hint_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q   <= '0;
				icnt_q  <= '0;
				ecnt_q  <= '0;
				plane_q <= hint_fix;
				start_q <= hint_fix;
				cut_q   <= 1'b0;
			end
			if (state_q == S_BUILD) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if ((state_q == S_TEST) && iss.valid) begin
				icnt_q  <= icnt_q + 3'd1;
				plane_q <= (plane_q == PLANE_LAST) ? 3'd0 : plane_q + 3'd1;
			end
			if (ev_test) begin
				ecnt_q <= ecnt_q + 3'd1;
				cut_q  <= cut_q | ev.cut;
			end
			if (reject) begin
				verdict_q <= VERDICT_OUTSIDE;
				hint_q    <= ev.plane;
			end else if (last) begin
				verdict_q <= (cut_q || ev.cut) ? VERDICT_CROSS : VERDICT_INSIDE;
				hint_q    <= start_q;
			end
		end
	end

	assign res_verdict = verdict_q;
	assign res_hint    = hint_q;

	a_eval_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= icnt_q)
		else $error("plane evaluated that was never issued");

	a_eval_window: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid |-> (state_q == S_TEST) || (state_q == S_DONE))
		else $error("plane test result outside the test window");

	a_flush_to_test: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |=> (state_q == S_TEST))
		else $error("rebuild flush did not lead into the test");

	a_build_from_stale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && in_valid && stale |=> (state_q == S_BUILD))
		else $error("stale planes were not rebuilt");

endmodule

[rtl/frustum_box_cull.sv]
`timescale 1ns / 1ps
// Top level of the frustum box cull block: config file, sequencer, datapath, result register.
// Depends on fbc_pkg, fbc_cfg, fbc_datapath and fbc_ctrl.
//
//  channel | direction | handshake           | beat carries
//  --------+-----------+---------------------+----------------------------------------
//  in      | input     | in_valid / in_stall | centre_x/y/z, extent_x/y/z, hint_in
//  out     | output    | out_valid/out_stall | verdict, hint_out
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (one 64-bit row)
//
// A box is taken in the idle state, then one plane is issued per cycle through the shared
// six-multiplier unit (products registered), with early exit on the first rejecting plane,
// and the result is handed off from the done state.
// After reset or any register write the next box first rebuilds the planes: 16 matrix entries
// through the same unit, then a flush state.
// Reset restores identity matrices and marks the planes stale; cfg_ready is always high.
// A result waiting under out_stall does not block the next box; only its hand-off waits.
module frustum_box_cull (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [15:0]            centre_x,
	input  logic signed [15:0]            centre_y,
	input  logic signed [15:0]            centre_z,
	input  logic [14:0]                   extent_x,
	input  logic [14:0]                   extent_y,
	input  logic [14:0]                   extent_z,
	input  logic [2:0]                    hint_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    verdict,
	output logic [2:0]                    hint_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbc_pkg::REG_W-1:0]     cfg_data
);
	import fbc_pkg::*;

	cfg_regs_t  regs;
	logic       stale;
	logic       stale_clear;
	logic       accept;
	logic       out_free;
	logic       load;
	logic [1:0] res_verdict;
	logic [2:0] res_hint;
	issue_t     iss;
	eval_t      ev;

	logic       out_valid_q;
	logic [1:0] verdict_q;
	logic [2:0] hint_q;

	assign cfg_ready = 1'b1;

	fbc_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (cfg_valid && cfg_ready),
		.wr_index    (cfg_index),
		.wr_data     (cfg_data),
		.stale_clear (stale_clear),
		.regs        (regs),
		.stale       (stale)
	);

	fbc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.hint_in     (hint_in),
		.stale       (stale),
		.out_free    (out_free),
		.ev          (ev),
		.in_stall    (in_stall),
		.accept      (accept),
		.stale_clear (stale_clear),
		.iss         (iss),
		.load        (load),
		.res_verdict (res_verdict),
		.res_hint    (res_hint)
	);

	fbc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.centre_x (centre_x),
		.centre_y (centre_y),
		.centre_z (centre_z),
		.extent_x (extent_x),
		.extent_y (extent_y),
		.extent_z (extent_z),
		.regs     (regs),
		.iss      (iss),
		.ev       (ev)
	);

	// Result register: load a finished beat, drop it once taken
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict_q <= res_verdict;
			hint_q    <= res_hint;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;
	assign hint_out  = hint_q;

endmodule
